### rtl/mcpf_pkg.sv
// Package for the motor command packet framer: packet types, constants
// and the byte-wide CRC-16 update. No dependencies.
package mcpf_pkg;

  localparam int unsigned PktLen       = 5;
  localparam int unsigned QueueDepthDf = 2;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] CrcInit      = 16'h0000;
  localparam logic [7:0]  SpeedMax     = 8'd127;

  // Command byte: bit 2 selects the motor, bit 0 selects backward.
  localparam logic [7:0]  CmdMotorBit  = 8'h04;
  localparam logic [7:0]  CmdBackBit   = 8'h01;

  // Position of a byte within the packet.
  typedef enum logic [2:0] {
    PosAddr  = 3'd0,
    PosCmd   = 3'd1,
    PosSpeed = 3'd2,
    PosCrcHi = 3'd3,
    PosCrcLo = 3'd4
  } pkt_pos_t;

  // One classified command, as it sits in the queue.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] mag;
  } pkt_hdr_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // CRC-16, MSB first: fold in one byte, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

### rtl/motor_command_packet_framer_core.sv
// Top level of the motor command packet framer: front end, header queue
// and byte sequencer. Depends on mcpf_pkg, mcpf_front, mcpf_queue, mcpf_back.
//
// Each command transaction (controller address, motor bit, signed speed)
// produces a five-byte packet on the output channel: address, command byte
// (0/4 forward, 1/5 backward for motor 0/1; speed >= 0 is forward), speed
// magnitude clamped to 127 (-128 gives 127), then CRC-16 (poly 0x1021,
// init 0, MSB first, no final xor) over those three bytes, high byte
// first. out_last marks the fifth byte. The output is one byte per
// transaction, so a packet is five transactions, paced by the byte
// sequencer's output register. A command is queued before its first
// byte is registered out. The front end classifies a command in the
// cycle it arrives and parks it in a QueueDepth-entry queue, so in_ready
// stays high while a packet is still being sent or stalled; it drops only
// when the queue is full. The CRC is folded one byte per cycle as bytes
// go out, held while stalled, so it is ready when the CRC bytes are due.
module motor_command_packet_framer_core #(
  parameter int unsigned QueueDepth = mcpf_pkg::QueueDepthDf  // 2..8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_controller_address,
  input  logic              in_motor,
  input  logic signed [7:0] in_speed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import mcpf_pkg::*;

  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;
  pkt_hdr_t q_wdata;
  pkt_hdr_t q_rdata;

  // Front end: accept and classify.
  mcpf_front u_front (
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_controller_address (in_controller_address),
    .in_motor              (in_motor),
    .in_speed              (in_speed),
    .q_stat                (q_stat),
    .q_push                (q_push),
    .q_wdata               (q_wdata)
  );

  // Decoupling queue.
  mcpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: serialize and append CRC.
  mcpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

### rtl/mcpf_front.sv
// Front end: takes a command transaction and builds the packet header
// (address, command byte, clamped speed magnitude). Uses mcpf_pkg.
module mcpf_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_controller_address,
  input  logic                in_motor,
  input  logic signed [7:0]   in_speed,
  input  mcpf_pkg::q_stat_t   q_stat,
  output logic                q_push,
  output mcpf_pkg::pkt_hdr_t  q_wdata
);
  import mcpf_pkg::*;

  logic       backward;
  logic [7:0] neg_mag;

  assign backward = in_speed[7];
  // Two's complement negate; only -128 lands above the clamp.
  assign neg_mag  = 8'(~in_speed) + 8'd1;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_wdata.addr = in_controller_address;
    q_wdata.cmd  = (in_motor ? CmdMotorBit : 8'h00) | (backward ? CmdBackBit : 8'h00);
    if (!backward) begin
      q_wdata.mag = in_speed;
    end else if (neg_mag > SpeedMax) begin
      q_wdata.mag = SpeedMax;
    end else begin
      q_wdata.mag = neg_mag;
    end
  end

endmodule

### rtl/mcpf_queue.sv
// Small register FIFO of packet headers between front and back end.
// Uses mcpf_pkg.
module mcpf_queue #(
  parameter int unsigned Depth = mcpf_pkg::QueueDepthDf  // 2..8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mcpf_pkg::pkt_hdr_t  wdata,
  input  logic                pop,
  output mcpf_pkg::pkt_hdr_t  rdata,
  output mcpf_pkg::q_stat_t   stat
);
  import mcpf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_hdr_t        mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CntW'(Depth));
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/mcpf_back.sv
// Back end: walks the head header out one byte per transaction, folds the
// first three bytes into the CRC and appends it. Uses mcpf_pkg.
module mcpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mcpf_pkg::q_stat_t   q_stat,
  input  mcpf_pkg::pkt_hdr_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import mcpf_pkg::*;

  pkt_pos_t    pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_base;
  logic        load;
  logic [7:0]  cur_byte;

  assign load     = !q_stat.empty && (!out_valid_r || out_ready);
  assign crc_base = (pos_r == PosAddr) ? CrcInit : crc_r;

  always_comb begin
    case (pos_r)
      PosAddr:  cur_byte = q_rdata.addr;
      PosCmd:   cur_byte = q_rdata.cmd;
      PosSpeed: cur_byte = q_rdata.mag;
      PosCrcHi: cur_byte = crc_r[15:8];
      PosCrcLo: cur_byte = crc_r[7:0];
      default:  cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = (pos_r == PosCrcLo);
      case (pos_r)
        PosAddr, PosCmd, PosSpeed: begin
          crc_nxt = crc_byte(crc_base, cur_byte);
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
      if (pos_r == PosCrcLo) begin
        pos_nxt = PosAddr;
        q_pop   = 1'b1;
      end else begin
        pos_nxt = pkt_pos_t'(pos_r + 3'd1);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= PosAddr;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  // While the final byte is shown, the sequencer is already back at the packet start.
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (pos_r == PosAddr))
    else $error("last byte shown but byte position not reset");

  // A header leaves the queue only with the final byte of its packet.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_last_r))
    else $error("queue popped without a last byte");

  // Mid-packet, the head header must still be present.
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != PosAddr) |-> !q_stat.empty)
    else $error("queue empty in the middle of a packet");

  // Byte position stays within the packet.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == PosAddr || pos_r == PosCmd || pos_r == PosSpeed ||
     pos_r == PosCrcHi || pos_r == PosCrcLo))
    else $error("byte position out of range");
`endif

endmodule

### tb/sv/mcpf_packet_checker.sv
`timescale 1ns / 100ps
// Packet checker for motor_command_packet_framer_core: predicts the five
// framed bytes of every accepted command and compares the output stream.
// Depends on mcpf_pkg.
module mcpf_packet_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_controller_address,
  input  logic              in_motor,
  input  logic signed [7:0] in_speed,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_byte,
  input  logic              out_last,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  import mcpf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } framed_byte_t;

  framed_byte_t packet_byte_q[$];
  int unsigned  n_fail = 0;

  // Bit-serial CRC-16 over address, command and magnitude (24 bits, MSB first).
  function automatic logic [15:0] header_crc16(input logic [23:0] hdr);
    logic [15:0] r;
    logic        fb;
    r = CrcInit;
    for (int i = 23; i >= 0; i--) begin
      fb = r[15] ^ hdr[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic void frame_command(input logic [7:0] addr, input logic motor,
                                        input logic [7:0] speed);
    logic [8:0]  mag;
    logic [7:0]  cmd;
    logic [15:0] crc;
    // two's complement magnitude, then saturate (-128 lands on 127)
    mag = speed[7] ? (9'd256 - {1'b0, speed}) : {1'b0, speed};
    if (mag > {1'b0, SpeedMax}) begin
      mag = {1'b0, SpeedMax};
    end
    cmd = (motor ? CmdMotorBit : 8'h00) | (speed[7] ? CmdBackBit : 8'h00);
    crc = header_crc16({addr, cmd, mag[7:0]});
    packet_byte_q.push_back('{data: addr,       last: 1'b0});
    packet_byte_q.push_back('{data: cmd,        last: 1'b0});
    packet_byte_q.push_back('{data: mag[7:0],   last: 1'b0});
    packet_byte_q.push_back('{data: crc[15:8],  last: 1'b0});
    packet_byte_q.push_back('{data: crc[7:0],   last: 1'b1});
  endfunction

  always @(posedge clk) begin
    framed_byte_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        frame_command(in_controller_address, in_motor, in_speed);
      end
      if (out_valid && out_ready) begin
        if (packet_byte_q.size() == 0) begin
          $error("unexpected output transaction: out_byte=%02h out_last=%0b",
                 out_byte, out_last);
          n_fail++;
        end else begin
          want = packet_byte_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_byte);
            n_fail++;
          end
          if (out_last !== want.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", want.last, out_last);
            n_fail++;
          end
        end
      end
    end
    fail_count <= n_fail;
    pending    <= packet_byte_q.size();
  end

endmodule

### tb/sv/tb_motor_command_packet_framer_core.sv
`timescale 1ns / 100ps
// Testbench top for motor_command_packet_framer_core: drives commands,
// randomizes flow control and gives the verdict. Depends on mcpf_pkg,
// mcpf_packet_checker and the framer RTL.
module tb_motor_command_packet_framer_core;

  // Worst case is roughly 420 commands x 5 bytes with heavy stalls on both
  // sides; this leaves a wide margin over that.
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseItems = 100;

  logic              clk                   = 1'b0;
  logic              rst_n                 = 1'b0;
  logic              in_valid              = 1'b0;
  logic              in_ready;
  logic [7:0]        in_controller_address = 8'h00;
  logic              in_motor              = 1'b0;
  logic signed [7:0] in_speed              = 8'sh00;
  logic              out_valid;
  logic              out_ready             = 1'b0;
  logic [7:0]        out_byte;
  logic              out_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  motor_command_packet_framer_core i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_controller_address (in_controller_address),
    .in_motor              (in_motor),
    .in_speed              (in_speed),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_byte              (out_byte),
    .out_last              (out_last)
  );

  // Scoreboard lives beside the DUT and only watches the two channels.
  mcpf_packet_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_controller_address (in_controller_address),
    .in_motor              (in_motor),
    .in_speed              (in_speed),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_byte              (out_byte),
    .out_last              (out_last),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // Receiver backpressure: a fresh coin per cycle, so stalls land on
  // every byte position of a packet, including the last one.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a lost packet ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One command transaction. in_valid is only dropped when an idle gap is
  // chosen, so back-to-back commands keep it high (one NBA per step).
  task automatic send_cmd(input logic [7:0] addr, input logic motor,
                          input logic [7:0] speed);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid              <= 1'b1;
    in_controller_address <= addr;
    in_motor              <= motor;
    in_speed              <= speed;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random command; about one in eight speeds is forced onto a boundary
  // (zero, -1, most negative, most positive) since those hit the clamp
  // and the direction flip.
  task automatic send_random_cmd();
    logic [7:0] speed;
    speed = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: speed = 8'h00;
        1: speed = 8'hFF;
        2: speed = 8'h80;
        default: speed = 8'h7F;
      endcase
    end
    send_cmd(8'($urandom_range(255)), 1'($urandom_range(1)), speed);
  endtask

  // Hold the sender off until every predicted byte has come out. The initial
  // wait lets a transaction accepted at this edge reach the checker.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PhaseItems) send_random_cmd();
    drain();
  endtask

  initial begin
    logic [7:0] dir_speed [8];
    logic [7:0] dir_addr  [4];
    dir_speed = '{8'h00, 8'h01, 8'h7F, 8'hFF, 8'h81, 8'h80, 8'h40, 8'hC0};
    dir_addr  = '{8'h00, 8'hFF, 8'hA5, 8'h5A};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both motors against zero, +/-1, full scale, -127, -128 and
    // mid values; covers all four command codes and the saturation case.
    // Addresses rotate through all-zero, all-one and both checkerboards.
    for (int s = 0; s < 8; s++) begin
      for (int m = 0; m < 2; m++) begin
        send_cmd(dir_addr[(2 * s + m) % 4], m[0], dir_speed[s]);
      end
    end
    drain();

    // Random phases with different flow-control mixes.
    run_phase(0, 0);
    run_phase(69, 0);
    run_phase(0, 69);
    run_phase(8, 8);

    // Wait out the pipeline before the verdict.
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/mcpf_pkg.sv
rtl/mcpf_front.sv
rtl/mcpf_queue.sv
rtl/mcpf_back.sv
rtl/motor_command_packet_framer_core.sv
tb/sv/mcpf_packet_checker.sv
tb/sv/tb_motor_command_packet_framer_core.sv
